// ===== src/rgbe_rle_pkg.sv =====
`timescale 1ns / 1ps

package rgbe_rle_pkg;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrMagic   = 2'd1,
    ErrWidth   = 2'd2,
    ErrOverrun = 2'd3
  } err_e;

  // one encoded byte with its resync flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       resync;
  } in_item_t;

  // one decoded segment or error report
  typedef struct packed {
    logic [1:0]  channel;
    logic [14:0] start_pos;
    logic [7:0]  run_length;
    logic [7:0]  value;
    logic        line_done;
    err_e        error;
  } seg_t;

  localparam logic [7:0]  MagicByte      = 8'd2;
  localparam logic [7:0]  LiteralMax     = 8'd128;
  localparam logic [14:0] LineWidthReset = 15'd8;
  localparam logic [14:0] MinLineWidth   = 15'd8;
  localparam logic [14:0] MaxLineWidth   = 15'h7fff;
  localparam logic [1:0]  ChanRed        = 2'd0;
  localparam logic [1:0]  ChanExp        = 2'd3;

endpackage

// ===== src/rgbe_rle_in_stage.sv =====
`timescale 1ns / 1ps

module rgbe_rle_in_stage import rgbe_rle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     valid_o,
  output in_item_t item_o,
  input  logic     pop_i
);

  logic     valid_q;
  in_item_t item_q;

  assign in_ready_o = !valid_q || pop_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ===== src/rgbe_rle_core.sv =====
`timescale 1ns / 1ps

module rgbe_rle_core import rgbe_rle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        fire_i,
  input  in_item_t    item_i,
  output logic        res_valid_o,
  output seg_t        res_o
);

  typedef enum logic [2:0] {
    PhMagic  = 3'd0,
    PhSkip   = 3'd1,
    PhWHigh  = 3'd2,
    PhWLow   = 3'd3,
    PhCode   = 3'd4,
    PhRunVal = 3'd5,
    PhLit    = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d, eff_phase;
  logic [1:0]  chan_q, chan_d, eff_chan;
  logic [14:0] pos_q, pos_d, eff_pos;
  logic [7:0]  pend_q, pend_d, eff_pend;
  logic [7:0]  whigh_q, whigh_d;
  logic [14:0] lwidth_q;

  logic [7:0]  b;
  logic        is_run;
  logic [7:0]  code_cnt;
  logic [7:0]  addend;
  logic [15:0] sum;
  logic [15:0] lw16;
  logic        over;
  logic        hit;

  assign b      = item_i.data_byte;
  assign is_run = (b > LiteralMax);
  assign code_cnt = is_run ? {1'b0, b[6:0]} : b;
  assign lw16   = {1'b0, lwidth_q};

  // resync drops the line in progress before the byte is looked at
  always_comb begin
    if (item_i.resync) begin
      eff_phase = PhMagic;
      eff_chan  = ChanRed;
      eff_pos   = '0;
      eff_pend  = '0;
    end else begin
      eff_phase = phase_q;
      eff_chan  = chan_q;
      eff_pos   = pos_q;
      eff_pend  = pend_q;
    end
  end

  // one shared adder for the overrun and end-of-channel checks
  always_comb begin
    case (eff_phase)
      PhCode:   addend = code_cnt;
      PhRunVal: addend = eff_pend;
      default:  addend = 8'd1;
    endcase
  end

  assign sum  = {1'b0, eff_pos} + {8'd0, addend};
  assign over = (sum > lw16);
  assign hit  = (sum == lw16);

  always_comb begin
    phase_d     = eff_phase;
    chan_d      = eff_chan;
    pos_d       = eff_pos;
    pend_d      = eff_pend;
    whigh_d     = whigh_q;
    res_valid_o = 1'b0;
    res_o.channel    = eff_chan;
    res_o.start_pos  = eff_pos;
    res_o.run_length = 8'd0;
    res_o.value      = b;
    res_o.line_done  = 1'b0;
    res_o.error      = ErrNone;

    case (eff_phase)
      PhMagic: begin
        if (b != MagicByte) begin
          res_valid_o = 1'b1;
          res_o.error = ErrMagic;
        end else begin
          phase_d = PhSkip;
        end
      end
      PhSkip: begin
        phase_d = PhWHigh;
      end
      PhWHigh: begin
        whigh_d = b;
        phase_d = PhWLow;
      end
      PhWLow: begin
        if ({whigh_q, b} != lw16 || lwidth_q < MinLineWidth
            || lwidth_q > MaxLineWidth) begin
          res_valid_o = 1'b1;
          res_o.error = ErrWidth;
        end else begin
          chan_d  = ChanRed;
          pos_d   = '0;
          pend_d  = '0;
          phase_d = PhCode;
        end
      end
      PhCode: begin
        if (b != 8'd0) begin
          if (over) begin
            res_valid_o = 1'b1;
            res_o.error = ErrOverrun;
          end else begin
            pend_d  = code_cnt;
            phase_d = is_run ? PhRunVal : PhLit;
          end
        end
      end
      PhRunVal, PhLit: begin
        if (over) begin
          res_valid_o = 1'b1;
          res_o.error = ErrOverrun;
        end else begin
          if (eff_phase == PhRunVal) begin
            pend_d  = '0;
            phase_d = PhCode;
          end else begin
            pend_d = eff_pend - 8'd1;
            if (pend_d == 8'd0) begin
              phase_d = PhCode;
            end
          end
          res_valid_o      = 1'b1;
          res_o.run_length = addend;
          res_o.line_done  = hit && (eff_chan == ChanExp);
          pos_d            = sum[14:0];
          if (hit) begin
            pos_d = '0;
            if (eff_chan == ChanExp) begin
              phase_d = PhMagic;
              chan_d  = ChanRed;
              pend_d  = '0;
            end else begin
              chan_d = eff_chan + 2'd1;
            end
          end
        end
      end
      default: begin
        phase_d = PhMagic;
        chan_d  = ChanRed;
        pos_d   = '0;
        pend_d  = '0;
      end
    endcase

    // every error drops back to the header
    if (res_o.error != ErrNone) begin
      phase_d = PhMagic;
      chan_d  = ChanRed;
      pos_d   = '0;
      pend_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhMagic;
      chan_q   <= ChanRed;
      pos_q    <= '0;
      pend_q   <= '0;
      whigh_q  <= '0;
      lwidth_q <= LineWidthReset;
    end else begin
      if (fire_i) begin
        phase_q <= phase_d;
        chan_q  <= chan_d;
        pos_q   <= pos_d;
        pend_q  <= pend_d;
        whigh_q <= whigh_d;
      end
      if (cfg_we_i) begin
        lwidth_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== src/rgbe_rle_out_stage.sv =====
`timescale 1ns / 1ps

module rgbe_rle_out_stage import rgbe_rle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  seg_t seg_i,
  output logic free_o,
  output logic valid_o,
  input  logic ready_i,
  output seg_t seg_o
);

  logic valid_q;
  seg_t seg_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign seg_o   = seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      seg_q <= seg_i;
    end
  end

endmodule

// ===== src/rgbe_scanline_rle_decoder.sv =====
`timescale 1ns / 1ps

// an accepted byte waits in the input register; its segment is loaded into the output register once that is free
// throughput: one byte per cycle, stalls only when the output register is held
// the decode path is one adder and compare between the input and output registers
// reset clears the decoder to wait for header byte zero, line width back to 8
// reset empties both the input and the output register

module rgbe_scanline_rle_decoder import rgbe_rle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: expected line width
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  // request side, one encoded byte per request
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        resync_i,
  // result side, one segment or error per request at most
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  channel_o,
  output logic [14:0] start_pos_o,
  output logic [7:0]  run_length_o,
  output logic [7:0]  value_o,
  output logic        line_done_o,
  output logic [1:0]  error_o
);

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     out_free;
  logic     fire;
  logic     res_valid;
  seg_t     res;
  seg_t     seg;

  assign in_item.data_byte = data_byte_i;
  assign in_item.resync    = resync_i;

  // the held byte is decoded as soon as the output register can take its result;
  // bytes that give no result still wait for that, which keeps ordering simple
  assign fire = item_valid && out_free;

  rgbe_rle_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .valid_o    (item_valid),
    .item_o     (item),
    .pop_i      (fire)
  );

  // header check, code parsing and position tracking
  rgbe_rle_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register parts the decoder from the consumer
  rgbe_rle_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && res_valid),
    .seg_i   (res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .seg_o   (seg)
  );

  assign channel_o    = seg.channel;
  assign start_pos_o  = seg.start_pos;
  assign run_length_o = seg.run_length;
  assign value_o      = seg.value;
  assign line_done_o  = seg.line_done;
  assign error_o      = seg.error;

`ifndef SYNTHESIS
  // error reports cover no pixels and never close a line
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_o != ErrNone) |-> (run_length_o == 8'd0) && !line_done_o)
    else $error("error result with nonzero run or line_done");

  // a good segment always covers at least one pixel
  a_seg_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_o == ErrNone) |-> (run_length_o != 8'd0))
    else $error("empty segment reported");

  // only the exponent channel can close a line
  a_done_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o |-> (channel_o == ChanExp))
    else $error("line_done outside exponent channel");

  // a held byte with a stalled result register blocks new requests
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && out_valid_o && !out_ready_i |-> !in_ready_o && !fire)
    else $error("request taken while pipeline is stalled");
`endif

endmodule

// ===== test/rgbe_scanline_rle_decoder_tb.sv =====
`timescale 1ns / 1ps

import rgbe_rle_pkg::*;

// tracks the decoder state per accepted byte and holds the segments still due
class rle_line_tracker;

  typedef enum logic [2:0] {
    DecMagic,
    DecSkip,
    DecWidthHi,
    DecWidthLo,
    DecCode,
    DecRunVal,
    DecLiteral
  } dec_phase_e;

  logic [14:0] line_width;
  dec_phase_e  phase;
  logic [1:0]  chan;
  logic [14:0] pos;
  logic [7:0]  pending_cnt;
  logic [7:0]  width_hi;
  seg_t        due_segments[$];
  int          bad_segments;

  function new();
    line_width   = LineWidthReset;
    width_hi     = '0;
    bad_segments = 0;
    restart_line();
  endfunction

  function void restart_line();
    phase       = DecMagic;
    chan        = ChanRed;
    pos         = '0;
    pending_cnt = '0;
  endfunction

  function void queue_seg(logic [7:0] len, logic [7:0] val, logic done, err_e err);
    seg_t s;
    s.channel    = chan;
    s.start_pos  = pos;
    s.run_length = len;
    s.value      = val;
    s.line_done  = done;
    s.error      = err;
    due_segments.push_back(s);
  endfunction

  function void reject(logic [7:0] val, err_e err);
    queue_seg(8'd0, val, 1'b0, err);
    restart_line();
  endfunction

  // segment that covers len pixels, steps to the next channel or line
  function void advance(logic [7:0] len, logic [7:0] val);
    int   next_pos;
    logic done;
    next_pos = int'(pos) + int'(len);
    done     = (next_pos == int'(line_width)) && (chan == ChanExp);
    queue_seg(len, val, done, ErrNone);
    pos = next_pos[14:0];
    if (next_pos == int'(line_width)) begin
      pos = '0;
      if (done) restart_line();
      else chan = chan + 2'd1;
    end
  endfunction

  function void take_byte(logic [7:0] b, logic rs);
    int cnt;
    if (rs) restart_line();
    case (phase)
      DecMagic: begin
        if (b != MagicByte) reject(b, ErrMagic);
        else phase = DecSkip;
      end
      DecSkip: phase = DecWidthHi;
      DecWidthHi: begin
        width_hi = b;
        phase    = DecWidthLo;
      end
      DecWidthLo: begin
        if ({width_hi, b} != {1'b0, line_width} || line_width < MinLineWidth) begin
          reject(b, ErrWidth);
        end else begin
          chan        = ChanRed;
          pos         = '0;
          pending_cnt = '0;
          phase       = DecCode;
        end
      end
      DecCode: begin
        if (b != 8'd0) begin
          cnt = (b > LiteralMax) ? int'(b & 8'h7f) : int'(b);
          if (int'(pos) + cnt > int'(line_width)) begin
            reject(b, ErrOverrun);
          end else begin
            pending_cnt = 8'(cnt);
            phase       = (b > LiteralMax) ? DecRunVal : DecLiteral;
          end
        end
      end
      DecRunVal: begin
        if (int'(pos) + int'(pending_cnt) > int'(line_width)) begin
          reject(b, ErrOverrun);
        end else begin
          cnt         = int'(pending_cnt);
          pending_cnt = '0;
          phase       = DecCode;
          advance(8'(cnt), b);
        end
      end
      DecLiteral: begin
        if (int'(pos) + 1 > int'(line_width)) begin
          reject(b, ErrOverrun);
        end else begin
          pending_cnt = pending_cnt - 8'd1;
          if (pending_cnt == 8'd0) phase = DecCode;
          advance(8'd1, b);
        end
      end
      default: restart_line();
    endcase
  endfunction

  function string seg_text(seg_t s);
    return $sformatf("ch %0d pos %0d len %0d val %02h done %0b err %0d",
                     s.channel, s.start_pos, s.run_length, s.value, s.line_done, s.error);
  endfunction

  function void match_segment(seg_t got);
    seg_t want;
    if (due_segments.size() == 0) begin
      bad_segments++;
      if (bad_segments <= 10) $display("segment with none due: %s", seg_text(got));
      return;
    end
    want = due_segments.pop_front();
    if (got.channel !== want.channel || got.start_pos !== want.start_pos ||
        got.run_length !== want.run_length || got.value !== want.value ||
        got.line_done !== want.line_done || got.error !== want.error) begin
      bad_segments++;
      if (bad_segments <= 10)
        $display("segment mismatch: expected %s, got %s", seg_text(want), seg_text(got));
    end
  endfunction

  function int outstanding();
    return due_segments.size();
  endfunction

endclass

module rgbe_scanline_rle_decoder_tb;

  // run limits and pacing
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 6;      // input and output register plus margin for quiet bytes
  localparam int HoldCycles   = 300;    // long receiver hold-off to fill the block
  localparam int IdlePct      = 9;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [14:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        resync_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  channel_o;
  logic [14:0] start_pos_o;
  logic [7:0]  run_length_o;
  logic [7:0]  value_o;
  logic        line_done_o;
  logic [1:0]  error_o;

  rle_line_tracker sb;

  // pacing controls for the driver and the receiver
  bit tx_idle_en;
  bit rx_idle_en;
  bit rx_hold_req;
  int rx_hold_left;
  int sent_items;
  int cycle_cnt = 0;

  // where the last generated line was cut off
  bit line_cut;
  int cut_rem;

  rgbe_scanline_rle_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .resync_i     (resync_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .channel_o    (channel_o),
    .start_pos_o  (start_pos_o),
    .run_length_o (run_length_o),
    .value_o      (value_o),
    .line_done_o  (line_done_o),
    .error_o      (error_o)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, long hold-off on request, none while idling is off
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_left = HoldCycles;
        rx_hold_req  = 1'b0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(99) < IdlePct) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // outputs are stable mid-cycle, so a segment seen here is taken at the next edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.match_segment('{channel_o, start_pos_o, run_length_o, value_o, line_done_o,
                         err_e'(error_o)});
  end

  function automatic logic [7:0] run_code(input int n);
    return 8'(int'(LiteralMax) + n);
  endfunction

  // one request, with an optional random one-cycle gap in front of it
  task automatic push_req(input logic [7:0] b, input logic rs = 1'b0);
    logic rdy;
    if (tx_idle_en && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    resync_i    <= rs;
    // ready sampled mid-cycle decides the handshake at the following edge
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    sb.take_byte(b, rs);
    sent_items++;
  endtask

  // stop sending, wait for every due segment, then let the pipe settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [14:0] w);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.line_width = w;
  endtask

  task automatic send_header(input int w, input logic rs = 1'b0);
    logic [15:0] hw;
    hw = 16'(w);
    push_req(MagicByte, rs);
    push_req(8'($urandom_range(255)));
    push_req(hw[15:8]);
    push_req(hw[7:0]);
  endtask

  // one code with its bytes: zero code, run or literal block, never past rem
  task automatic send_group(input int rem, output int used);
    int pick;
    int cnt;
    pick = $urandom_range(99);
    used = 0;
    if (pick < 8) begin
      push_req(8'd0);
    end else if (pick < 55) begin
      cnt = $urandom_range((rem < 127) ? rem : 127, 1);
      push_req(run_code(cnt));
      push_req(8'($urandom_range(255)));
      used = cnt;
    end else begin
      // mostly short literal blocks, now and then up to the full 128
      if ($urandom_range(9) == 0) cnt = (rem < 128) ? rem : 128;
      else cnt = (rem < 12) ? rem : 12;
      cnt = $urandom_range(cnt, 1);
      push_req(8'(cnt));
      repeat (cnt) push_req(8'($urandom_range(255)));
      used = cnt;
    end
  endtask

  // full scanline, or cut off after budget codes when budget is not negative
  task automatic send_line(input int w, input int budget, input logic rs);
    int rem;
    int used;
    line_cut = 1'b0;
    send_header(w, rs);
    for (int ch = 0; ch < 4; ch++) begin
      rem = w;
      while (rem > 0) begin
        if (budget == 0) begin
          line_cut = 1'b1;
          cut_rem  = rem;
          return;
        end
        budget--;
        send_group(rem, used);
        rem -= used;
      end
    end
  endtask

  // broken streams: stray bytes, bad header width, overrun, resync mid-line
  task automatic send_broken(input int w);
    case ($urandom_range(4))
      0: push_req(8'($urandom_range(255)), 1'($urandom_range(1)));
      1: begin
        if ($urandom_range(1)) send_header(w ^ (1 << $urandom_range(15)));
        else send_header($urandom_range(65535));
      end
      2: begin
        send_line(w, $urandom_range(20), 1'b1);
        if (line_cut && cut_rem < 128) begin
          if (cut_rem < 127 && $urandom_range(1))
            push_req(run_code($urandom_range(127, cut_rem + 1)));
          else
            push_req(8'($urandom_range(128, cut_rem + 1)));
        end
      end
      3: begin
        // abandon a partial line, restart with resync on the magic byte
        send_line(w, $urandom_range(20), 1'b1);
        send_line(w, (w > 1000) ? 0 : -1, 1'b1);
      end
      default: begin
        repeat ($urandom_range(6, 1))
          push_req(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    endcase
  endtask

  initial begin
    int quota[8];
    int w;
    int goal;
    int cut;
    quota = '{250, 120, 250, 350, 250, 250, 250, 200};
    sb = new();
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    rx_hold_req  = 1'b0;
    rx_hold_left = 0;
    sent_items   = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    resync_i    <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset width 8
    push_req(8'hff, 1'b1);                 // bad magic, resync on the same byte
    push_req(MagicByte);
    push_req(8'hff);
    push_req(8'h00);
    push_req(8'h08);
    push_req(run_code(8));                 // red: one run covers the channel
    push_req(8'hff);
    push_req(8'd2);                        // green: two literals then a run of six
    push_req(8'h00);
    push_req(8'h80);
    push_req(run_code(6));
    push_req(8'h00);
    push_req(8'd0);                        // blue: zero code adds nothing
    push_req(run_code(4));
    push_req(8'h7f);
    push_req(run_code(5));                 // overrun on the code byte
    push_req(MagicByte);                   // width mismatch in the high byte
    push_req(8'h00);
    push_req(8'hff);
    push_req(8'h08);

    // width shrinks while a run value is pending: overrun caught on the value
    drain_results();
    write_width(15'd16);
    send_header(16);
    push_req(8'd3);
    push_req(8'h01);
    push_req(8'hfe);
    push_req(8'h55);
    push_req(run_code(6));
    drain_results();
    write_width(MinLineWidth);
    push_req(8'h5a);

    // random phases, each writing its line width anew
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      // phase 4 runs without any idling on either side
      tx_idle_en = (ph != 4);
      rx_idle_en = (ph != 4);
      case (ph)
        1: w = int'(MaxLineWidth);
        2: w = $urandom_range(24, 9);
        3: w = 200;
        4: w = $urandom_range(40, 8);
        5: w = $urandom_range(16, 8);
        6: w = 256;
        default: w = int'(MinLineWidth);
      endcase
      write_width(15'(w));
      // receiver holds off while bytes keep coming, so the input stalls
      if (ph == 5) rx_hold_req = 1'b1;
      goal = sent_items + quota[ph];
      while (sent_items < goal) begin
        if ($urandom_range(99) < 75) begin
          // the widest lines are only ever started, then dropped by resync
          cut = -1;
          if (w > 1000) cut = $urandom_range(12);
          send_line(w, cut, (w > 1000) || ($urandom_range(3) == 0));
        end else begin
          send_broken(w);
        end
      end
    end

    drain_results();
    if (sb.bad_segments == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
